FILE: hw/rtl/lru_block_cache_macros.svh
// ----------------------------------------------------------------------------
// lru_block_cache_macros.svh
// Assertion macros shared by the LRU block cache modules. Each macro expects
// signals named clk and rst_n in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_CACHE_MACROS_SVH
`define LRU_BLOCK_CACHE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Types and constants shared by the LRU block cache modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbc_pkg;

  localparam int ENTRIES    = 16;
  localparam int DATA_WIDTH = 64;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int RANK_W     = IDX_W;
  localparam int CNT_W      = $clog2(ENTRIES + 1);

  localparam logic [4:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    MODE_GET   = 2'd0,
    MODE_PUT   = 2'd1,
    MODE_INVAL = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] block_number;
    logic [63:0] write_data;
  } in_req_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] read_data;
    logic [4:0]  occupancy;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] eviction_count;
    logic [32:0] request_count;
  } out_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic trim;
    logic lookup;
    logic update;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic over_cap;
  } stat_t;

endpackage

FILE: hw/rtl/lbc_datapath.sv
// ----------------------------------------------------------------------------
// lbc_datapath
// Entry storage, parallel tag compare, recency ranks, counters and the
// result register of the LRU block cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_block_cache_macros.svh"

module lbc_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  lbc_pkg::cmd_t    cmd,
  output lbc_pkg::stat_t   stat,
  input  lbc_pkg::in_req_t in_req,
  input  logic             cfg_we,
  input  logic [4:0]       cfg_wdata,
  output lbc_pkg::out_rsp_t out_rsp
);

  localparam int E = lbc_pkg::ENTRIES;

  logic [lbc_pkg::DATA_WIDTH-1:0] data_r [E];
  logic [31:0]                    key_r  [E];
  logic [lbc_pkg::RANK_W-1:0]     rank_r [E];
  logic [lbc_pkg::RANK_W-1:0]     rank_nxt [E];
  logic [lbc_pkg::RANK_W-1:0]     touch_rank [E];
  logic [E-1:0]                   valid_r, valid_nxt;
  logic [E-1:0]                   match_r;
  logic [lbc_pkg::CNT_W-1:0]      total_r, total_nxt, eff_cap;
  logic [31:0]                    hits_r, hits_nxt;
  logic [31:0]                    miss_r, miss_nxt;
  logic [31:0]                    evict_r, evict_nxt;
  logic [4:0]                     cap_r;
  lbc_pkg::in_req_t               req_r;
  lbc_pkg::out_rsp_t              out_r;

  logic [E-1:0]                   lru_vec, evict_vec, free_vec, ins_vec, key_we, data_we;
  logic                           hit_any, evict_now, hit_nxt;
  logic [lbc_pkg::RANK_W-1:0]     hit_rank, lru_rank;
  logic [lbc_pkg::DATA_WIDTH-1:0] hit_data;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == '1) ? c : c + 32'd1;
  endfunction

  // Capacity of zero acts as one, anything above the entry count as full size.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = lbc_pkg::CNT_W'(1);
    end else if (int'(cap_r) > E) begin
      eff_cap = lbc_pkg::CNT_W'(E);
    end else begin
      eff_cap = lbc_pkg::CNT_W'(cap_r);
    end
  end

  assign stat.over_cap = (total_r > eff_cap);
  assign evict_now     = (total_r >= eff_cap);
  assign lru_rank      = lbc_pkg::RANK_W'(total_r - 1'b1);

  // Valid ranks are distinct and dense, so the least recent entry is the one
  // ranked one below the occupancy.
  always_comb begin
    hit_rank = '0;
    hit_data = '0;
    for (int i = 0; i < E; i++) begin
      lru_vec[i] = valid_r[i] && (rank_r[i] == lru_rank);
      if (match_r[i]) begin
        hit_rank = hit_rank | rank_r[i];
        hit_data = hit_data | data_r[i];
      end
    end
  end

  assign hit_any   = |match_r;
  assign evict_vec = evict_now ? lru_vec : '0;
  assign free_vec  = ~valid_r | evict_vec;
  assign ins_vec   = free_vec & (~free_vec + 1'b1);

  always_comb begin
    for (int i = 0; i < E; i++) begin
      if (match_r[i]) begin
        touch_rank[i] = '0;
      end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
        touch_rank[i] = rank_r[i] + 1'b1;
      end else begin
        touch_rank[i] = rank_r[i];
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    total_nxt = total_r;
    hits_nxt  = hits_r;
    miss_nxt  = miss_r;
    evict_nxt = evict_r;
    key_we    = '0;
    data_we   = '0;
    hit_nxt   = 1'b0;
    if (cmd.trim) begin
      valid_nxt = valid_r & ~lru_vec;
      total_nxt = total_r - 1'b1;
      evict_nxt = sat_inc(evict_r);
    end else if (cmd.update) begin
      case (req_r.mode)
        lbc_pkg::MODE_GET: begin
          if (hit_any) begin
            rank_nxt = touch_rank;
            hits_nxt = sat_inc(hits_r);
            hit_nxt  = 1'b1;
          end else begin
            miss_nxt = sat_inc(miss_r);
          end
        end
        lbc_pkg::MODE_PUT: begin
          if (hit_any) begin
            rank_nxt = touch_rank;
            data_we  = match_r;
          end else if (ins_vec != '0) begin
            for (int i = 0; i < E; i++) begin
              if (ins_vec[i]) begin
                valid_nxt[i] = 1'b1;
                rank_nxt[i]  = '0;
              end else if (evict_vec[i]) begin
                valid_nxt[i] = 1'b0;
              end else if (valid_r[i]) begin
                rank_nxt[i] = rank_r[i] + 1'b1;
              end
            end
            key_we  = ins_vec;
            data_we = ins_vec;
            if (evict_now) begin
              evict_nxt = sat_inc(evict_r);
            end else begin
              total_nxt = total_r + 1'b1;
            end
          end
        end
        lbc_pkg::MODE_INVAL: begin
          if (hit_any) begin
            valid_nxt = valid_r & ~match_r;
            total_nxt = total_r - 1'b1;
            for (int i = 0; i < E; i++) begin
              if (valid_r[i] && (rank_r[i] > hit_rank)) begin
                rank_nxt[i] = rank_r[i] - 1'b1;
              end
            end
          end
        end
        lbc_pkg::MODE_CLEAR: begin
          valid_nxt = '0;
          total_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      total_r <= '0;
      hits_r  <= '0;
      miss_r  <= '0;
      evict_r <= '0;
      cap_r   <= lbc_pkg::CAP_RESET;
    end else begin
      valid_r <= valid_nxt;
      total_r <= total_nxt;
      hits_r  <= hits_nxt;
      miss_r  <= miss_nxt;
      evict_r <= evict_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    if (cmd.lookup) begin
      for (int i = 0; i < E; i++) begin
        match_r[i] <= valid_r[i] && (key_r[i] == req_r.block_number);
      end
    end
    for (int i = 0; i < E; i++) begin
      rank_r[i] <= rank_nxt[i];
      if (key_we[i]) begin
        key_r[i] <= req_r.block_number;
      end
      if (data_we[i]) begin
        data_r[i] <= req_r.write_data[lbc_pkg::DATA_WIDTH-1:0];
      end
    end
    if (cmd.update) begin
      out_r.hit            <= hit_nxt;
      out_r.read_data      <= hit_nxt ? 64'(hit_data) : 64'd0;
      out_r.occupancy      <= 5'(total_nxt);
      out_r.hit_count      <= hits_nxt;
      out_r.miss_count     <= miss_nxt;
      out_r.eviction_count <= evict_nxt;
      out_r.request_count  <= {1'b0, hits_nxt} + {1'b0, miss_nxt};
    end
  end

  assign out_rsp = out_r;

  `LBC_ASSERT_SAME(a_total_matches_valid, 1'b1, $countones(valid_r) == int'(total_r), "occupancy does not match valid entries")
  `LBC_ASSERT_SAME(a_total_in_range, 1'b1, int'(total_r) <= E, "occupancy above entry count")
  `LBC_ASSERT_NEXT(a_match_onehot, cmd.lookup, $onehot0(match_r), "key found in more than one entry")

endmodule

FILE: hw/rtl/lbc_ctrl.sv
// ----------------------------------------------------------------------------
// lbc_ctrl
// Sequencer of the LRU block cache: request acceptance, capacity trimming,
// lookup and update steps, and the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_block_cache_macros.svh"

module lbc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  lbc_pkg::stat_t stat,
  output lbc_pkg::cmd_t  cmd
);

  lbc_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      lbc_pkg::ST_IDLE: begin
        // Requests are held off until reset has been released.
        in_stall = !rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = lbc_pkg::ST_LOOKUP;
        end
      end
      lbc_pkg::ST_LOOKUP: begin
        if (stat.over_cap) begin
          cmd.trim = 1'b1;
        end else begin
          cmd.lookup = 1'b1;
          state_nxt  = lbc_pkg::ST_UPDATE;
        end
      end
      lbc_pkg::ST_UPDATE: begin
        if (out_free) begin
          cmd.update = 1'b1;
          in_stall   = 1'b0;
          if (in_valid) begin
            cmd.load  = 1'b1;
            state_nxt = lbc_pkg::ST_LOOKUP;
          end else begin
            state_nxt = lbc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = lbc_pkg::ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.update || (out_valid_r && out_stall);
  end

  assign out_valid = out_valid_r;

  `LBC_ASSERT_NEXT(a_update_sets_valid, cmd.update, out_valid_r, "result not presented after update")
  `LBC_ASSERT_SAME(a_update_needs_room, cmd.update, out_free, "result register overwritten")
  `LBC_ASSERT_SAME(a_trim_only_in_lookup, cmd.trim, state_r == lbc_pkg::ST_LOOKUP, "trim outside lookup")

endmodule

FILE: hw/rtl/lru_block_cache.sv
// ----------------------------------------------------------------------------
// lru_block_cache
// Fully associative block cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Each request carries a get, put, invalidate or clear on a block number and
// returns exactly one response with the hit flag, read data, occupancy and
// the saturating hit, miss and eviction counters. A request runs through a
// lookup step, which registers the parallel compare of the key against all
// sixteen entries, and an update step, which applies the rank update and
// loads the response register. A back-to-back request is accepted in the
// same cycle as the update step of the request before it. After the capacity
// register is lowered below the occupancy, the next request first evicts
// least-recent entries, one per trim step, until occupancy equals capacity.
// A new request is accepted while the previous response still waits in the
// output register; the update step waits only if that register is full and
// stalled. The capacity register is written through cfg_we and cfg_wdata
// and should be written only while no request is in flight.
module lru_block_cache (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lbc_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output lbc_pkg::out_rsp_t out_rsp,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata
);

  // Command and status buses between the sequencer and the datapath.
  lbc_pkg::cmd_t  cmd;
  lbc_pkg::stat_t stat;

  // The sequencer owns acceptance, the trim loop and the response valid flag.
  lbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds entries, ranks, counters, capacity and the response.
  lbc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_rsp   (out_rsp)
  );

endmodule

FILE: test/lru_block_cache_test.sv
// ----------------------------------------------------------------------------
// lru_block_cache_test
// Self-checking testbench for the LRU block cache. A scoreboard class keeps
// its own copy of the cache contents, recency order and counters, predicts
// one response per accepted request and compares it field by field with what
// the block returns, under random idling on both channels and a range of
// capacity settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_block_cache_test;

  // Generous cycle budget; the slowest legal run is far below this.
  localparam int CYCLE_LIMIT    = 200000;
  localparam int ITEMS_PER_STEP = 95;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the cache and holds the responses still owed.
  // --------------------------------------------------------------------------
  class lru_scoreboard;
    logic                           slot_valid [lbc_pkg::ENTRIES];
    logic [31:0]                    slot_key   [lbc_pkg::ENTRIES];
    logic [lbc_pkg::DATA_WIDTH-1:0] slot_data  [lbc_pkg::ENTRIES];
    logic [lbc_pkg::RANK_W-1:0]     slot_rank  [lbc_pkg::ENTRIES];
    logic [lbc_pkg::CNT_W-1:0]      occupancy;
    logic [31:0]                    hits, misses, evictions;
    logic [4:0]                     capacity;
    lbc_pkg::out_rsp_t              expected_q [$];
    int                             mismatches;
    int                             responses;
    int                             requests;

    function new();
      for (int i = 0; i < lbc_pkg::ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i]   = '0;
        slot_data[i]  = '0;
        slot_rank[i]  = '0;
      end
      occupancy  = '0;
      hits       = '0;
      misses     = '0;
      evictions  = '0;
      capacity   = lbc_pkg::CAP_RESET;
      mismatches = 0;
      responses  = 0;
      requests   = 0;
    endfunction

    function void note_capacity(logic [4:0] value);
      capacity = value;
    endfunction

    // Zero behaves as one and anything past the array size as the array size.
    function int room();
      if (capacity == 0) return 1;
      if (capacity > lbc_pkg::ENTRIES) return lbc_pkg::ENTRIES;
      return int'(capacity);
    endfunction

    function logic [31:0] bump(logic [31:0] c);
      return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    function int lookup(logic [31:0] key);
      for (int i = 0; i < lbc_pkg::ENTRIES; i++)
        if (slot_valid[i] && slot_key[i] == key) return i;
      return -1;
    endfunction

    // Move a slot to the front; everything newer than it ages by one.
    function void promote(int s);
      for (int i = 0; i < lbc_pkg::ENTRIES; i++)
        if (slot_valid[i] && slot_rank[i] < slot_rank[s]) slot_rank[i]++;
      slot_rank[s] = '0;
    endfunction

    // Remove a slot and close the gap it leaves in the recency order.
    function void drop_slot(int s);
      slot_valid[s] = 1'b0;
      for (int i = 0; i < lbc_pkg::ENTRIES; i++)
        if (slot_valid[i] && slot_rank[i] > slot_rank[s]) slot_rank[i]--;
      if (occupancy != 0) occupancy--;
    endfunction

    function void evict_oldest();
      int victim;
      victim = -1;
      for (int i = 0; i < lbc_pkg::ENTRIES; i++)
        if (slot_valid[i] && (victim < 0 || slot_rank[i] >= slot_rank[victim]))
          victim = i;
      if (victim >= 0) begin
        drop_slot(victim);
        evictions = bump(evictions);
      end
    endfunction

    function void note_request(lbc_pkg::in_req_t req);
      lbc_pkg::out_rsp_t rsp;
      int                s;
      int                free_slot;
      rsp = '0;
      requests++;
      // A lowered capacity takes effect before the request itself.
      while (occupancy > room()) evict_oldest();
      case (req.mode)
        lbc_pkg::MODE_GET: begin
          s = lookup(req.block_number);
          if (s >= 0) begin
            promote(s);
            rsp.hit       = 1'b1;
            rsp.read_data = 64'(slot_data[s]);
            hits          = bump(hits);
          end else begin
            misses = bump(misses);
          end
        end
        lbc_pkg::MODE_PUT: begin
          s = lookup(req.block_number);
          if (s >= 0) begin
            promote(s);
            slot_data[s] = req.write_data[lbc_pkg::DATA_WIDTH-1:0];
          end else begin
            if (occupancy >= room()) evict_oldest();
            free_slot = -1;
            for (int i = lbc_pkg::ENTRIES - 1; i >= 0; i--)
              if (!slot_valid[i]) free_slot = i;
            if (free_slot >= 0) begin
              for (int i = 0; i < lbc_pkg::ENTRIES; i++)
                if (slot_valid[i]) slot_rank[i]++;
              slot_valid[free_slot] = 1'b1;
              slot_key[free_slot]   = req.block_number;
              slot_data[free_slot]  = req.write_data[lbc_pkg::DATA_WIDTH-1:0];
              slot_rank[free_slot]  = '0;
              occupancy++;
            end
          end
        end
        lbc_pkg::MODE_INVAL: begin
          s = lookup(req.block_number);
          if (s >= 0) drop_slot(s);
        end
        default: begin
          for (int i = 0; i < lbc_pkg::ENTRIES; i++) slot_valid[i] = 1'b0;
          occupancy = '0;
        end
      endcase
      rsp.occupancy      = occupancy;
      rsp.hit_count      = hits;
      rsp.miss_count     = misses;
      rsp.eviction_count = evictions;
      rsp.request_count  = {1'b0, hits} + {1'b0, misses};
      expected_q.push_back(rsp);
    endfunction

    task flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("[%0t] MISMATCH response %0d %s: got %h expected %h",
               $realtime, responses, what, got, want);
    endtask

    task check_response(lbc_pkg::out_rsp_t got);
      lbc_pkg::out_rsp_t want;
      responses++;
      if (expected_q.size() == 0) begin
        flag_mismatch("arrived with no request pending", 64'(got.occupancy), 64'd0);
      end else begin
        want = expected_q.pop_front();
        if (got.hit !== want.hit)
          flag_mismatch("hit", 64'(got.hit), 64'(want.hit));
        if (got.read_data !== want.read_data)
          flag_mismatch("read_data", got.read_data, want.read_data);
        if (got.occupancy !== want.occupancy)
          flag_mismatch("occupancy", 64'(got.occupancy), 64'(want.occupancy));
        if (got.hit_count !== want.hit_count)
          flag_mismatch("hit_count", 64'(got.hit_count), 64'(want.hit_count));
        if (got.miss_count !== want.miss_count)
          flag_mismatch("miss_count", 64'(got.miss_count), 64'(want.miss_count));
        if (got.eviction_count !== want.eviction_count)
          flag_mismatch("eviction_count", 64'(got.eviction_count),
                        64'(want.eviction_count));
        if (got.request_count !== want.request_count)
          flag_mismatch("request_count", 64'(got.request_count),
                        64'(want.request_count));
      end
    endtask

    task check_leftover();
      if (expected_q.size() != 0)
        flag_mismatch("responses never returned", 64'(expected_q.size()), 64'd0);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals, clock and the block under test.
  // --------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  lbc_pkg::in_req_t  in_req;
  logic              out_valid;
  logic              out_stall;
  lbc_pkg::out_rsp_t out_rsp;
  logic              cfg_we;
  logic [4:0]        cfg_wdata;

  // When set, neither side inserts idle cycles, so requests run back to back.
  bit        calm = 1'b0;
  int        cycle_count = 0;

  lru_scoreboard sb = new();

  always #2 clk = ~clk;

  lru_block_cache uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", CYCLE_LIMIT);
      $display("** lru_block_cache: FAILED **");
      $finish;
    end
  end

  // Every request the block takes is handed to the scoreboard at the edge
  // that takes it. Signals are read before this edge's updates land, so the
  // sampled values are the ones the block saw.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_req);
  end

  // Response side: after each taken response, stall for a random number of
  // cycles. The countdown runs whether or not a response is waiting, so the
  // stalls land on every phase of the block's lookup and update steps.
  initial begin
    int rsp_hold;
    rsp_hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_response(out_rsp);
        rsp_hold = calm ? 0 : $urandom_range(0, 3);
        out_stall <= (rsp_hold != 0);
      end else if (rsp_hold != 0) begin
        rsp_hold--;
        out_stall <= (rsp_hold != 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request driver. It is entered right after a rising edge. Valid is left
  // high after a request is taken, so a request with no gap simply replaces
  // the payload and valid is never dropped and raised in the same step.
  // --------------------------------------------------------------------------
  task automatic send_request(input lbc_pkg::mode_t mode, input logic [31:0] key,
                              input logic [63:0] data);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.mode         <= mode;
    in_req.block_number <= key;
    in_req.write_data   <= data;
    in_valid            <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every owed response has been taken, then a
  // few more cycles so the block is fully idle. The first edge lets the
  // scoreboard record a request taken at the edge this task is entered on.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The capacity register is only written while the block is idle. The
  // scoreboard learns the new value at the same time; any eviction it causes
  // shows up on the next request.
  task automatic write_capacity(input logic [4:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.note_capacity(value);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    logic [4:0]     step_caps [9];
    logic [31:0]    key_pool [$];
    logic [31:0]    key;
    lbc_pkg::mode_t mode;
    int             eff_cap;
    int             pick;
    int             settings;

    step_caps = '{5'd31, 5'd4, 5'd16, 5'd1, 5'd0, 5'd9, 5'd17, 5'd2, 5'd16};
    in_valid  <= 1'b0;
    in_req    <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    settings  = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: key and data extremes on an empty cache, hits, an update of
    // an existing entry, invalidation of a present and of an absent key, and
    // a clear that must keep the counters.
    send_request(lbc_pkg::MODE_GET,   32'h0000_0000, 64'h0);
    send_request(lbc_pkg::MODE_PUT,   32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(lbc_pkg::MODE_PUT,   32'hFFFF_FFFF, 64'h0);
    send_request(lbc_pkg::MODE_GET,   32'h0000_0000, 64'h0);
    send_request(lbc_pkg::MODE_GET,   32'hFFFF_FFFF, 64'h0);
    send_request(lbc_pkg::MODE_PUT,   32'h0000_0000, 64'hA5A5_5A5A_0F0F_F0F0);
    send_request(lbc_pkg::MODE_INVAL, 32'hFFFF_FFFF, 64'h0);
    send_request(lbc_pkg::MODE_INVAL, 32'h0000_0123, 64'h0);
    send_request(lbc_pkg::MODE_CLEAR, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(lbc_pkg::MODE_GET,   32'h0000_0000, 64'h0);

    // Fill all sixteen slots, then lower the capacity well below the
    // occupancy: the next request must first evict the thirteen oldest.
    for (int i = 1; i <= lbc_pkg::ENTRIES; i++)
      send_request(lbc_pkg::MODE_PUT, 32'h0000_1000 + i, {$urandom, $urandom});
    settle();
    write_capacity(5'd3);
    settings++;
    send_request(lbc_pkg::MODE_GET, 32'h0000_1000 + lbc_pkg::ENTRIES, 64'h0);

    // Random steps, one per capacity setting. The sender pauses until all
    // responses are back before each register write. Each step draws its own
    // key pool a little larger than the effective capacity, so gets hit,
    // puts both update and insert, and full-cache evictions happen. A tenth
    // of the keys are fresh random values.
    for (int p = 0; p < 9; p++) begin
      settle();
      write_capacity(step_caps[p]);
      settings++;
      calm    = (p % 3 == 2);
      eff_cap = (step_caps[p] == 0) ? 1 :
                (step_caps[p] > lbc_pkg::ENTRIES) ? lbc_pkg::ENTRIES : int'(step_caps[p]);
      key_pool.delete();
      key_pool.push_back(32'h0000_0000);
      key_pool.push_back(32'hFFFF_FFFF);
      repeat (eff_cap + eff_cap / 2) key_pool.push_back($urandom);
      repeat (ITEMS_PER_STEP) begin
        pick = $urandom_range(0, 99);
        if (pick < 42)      mode = lbc_pkg::MODE_GET;
        else if (pick < 80) mode = lbc_pkg::MODE_PUT;
        else if (pick < 97) mode = lbc_pkg::MODE_INVAL;
        else                mode = lbc_pkg::MODE_CLEAR;
        if ($urandom_range(0, 9) == 0) key = $urandom;
        else key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        send_request(mode, key, {$urandom, $urandom});
      end
    end
    calm = 1'b0;

    // Drain, then allow a few extra cycles for any stray response.
    settle();
    repeat (10) @(posedge clk);
    sb.check_leftover();

    $display("Ran %0d requests across %0d capacity settings, with %0d hits,",
             sb.requests, settings, sb.hits);
    $display("%0d misses and %0d evictions; %0d responses checked, %0d mismatches.",
             sb.misses, sb.evictions, sb.responses, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("** lru_block_cache: PASSED **");
    end else begin
      $display("** lru_block_cache: FAILED **");
    end
    $finish;
  end

endmodule
